// ----- hw/rtl/mvc_pkg.sv -----
// Package for the motion vector to color block: constants, types and the angle table.
package mvc_pkg;

  localparam int MV_WIDTH_DEF     = 14;
  localparam int ANGLE_STAGES_DEF = 16;

  localparam int MAG_W     = 11;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int LIM_W     = SQ_W + 4;
  localparam int S_SHIFT   = 28;
  localparam int V_SHIFT   = 32;
  localparam int Q_W       = 33;
  localparam int ROOT_W    = 17;
  localparam int HUE_W     = 19;
  localparam int FRAC_W    = 16;
  localparam int SEC_W     = HUE_W - FRAC_W;
  localparam int ANG_W     = 16;
  localparam int CHAN_W    = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [MAG_W-1:0] MAX_MAG_RESET = 11'd40;
  localparam logic [0:0]       REG_MAX_MAG   = 1'b0;

  localparam int HUE_FULL = 393216;
  localparam int HUE_HALF = 196608;

  typedef struct packed {
    logic              over;
    logic [ROOT_W-1:0] root;
    logic [HUE_W-1:0]  hue;
  } mvc_pix_t;

  // atan(2^-i), 60 degrees = 65536
  function automatic logic [ANG_W-1:0] atan_angle(input int unsigned i);
    logic [ANG_W-1:0] a;
    case (i)
      0:       a = 16'd49152;
      1:       a = 16'd29016;
      2:       a = 16'd15331;
      3:       a = 16'd7782;
      4:       a = 16'd3906;
      5:       a = 16'd1955;
      6:       a = 16'd978;
      7:       a = 16'd489;
      8:       a = 16'd244;
      9:       a = 16'd122;
      10:      a = 16'd61;
      11:      a = 16'd31;
      12:      a = 16'd15;
      13:      a = 16'd8;
      14:      a = 16'd4;
      15:      a = 16'd2;
      16:      a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/mvc_cordic.sv -----
// CORDIC vectoring pipeline that turns a motion vector into a hue angle.
module mvc_cordic #(
  parameter int MV_WIDTH     = mvc_pkg::MV_WIDTH_DEF,
  parameter int ANGLE_STAGES = mvc_pkg::ANGLE_STAGES_DEF
) (
  input  logic                             clk,
  input  logic signed [MV_WIDTH-1:0]       x,
  input  logic signed [MV_WIDTH-1:0]       y,
  output logic [mvc_pkg::HUE_W-1:0]        hue
);

  localparam int CW = MV_WIDTH + 11;
  localparam int ZW = mvc_pkg::HUE_W + 1;

  logic signed [CW-1:0] xs_q [ANGLE_STAGES];
  logic signed [CW-1:0] ys_q [ANGLE_STAGES];
  logic signed [ZW-1:0] z_q  [ANGLE_STAGES];
  logic                 neg_q  [ANGLE_STAGES];
  logic                 zero_q [ANGLE_STAGES];

  logic signed [CW-1:0] xs_next [ANGLE_STAGES];
  logic signed [CW-1:0] ys_next [ANGLE_STAGES];
  logic signed [ZW-1:0] z_next  [ANGLE_STAGES];

  logic signed [CW-1:0] xe, ye;
  logic                 neg_in, zero_in;
  logic signed [ZW-1:0] h_sum;

  always_comb begin
    logic signed [CW-1:0] pxs, pys, dx, dy;
    logic signed [ZW-1:0] pz, ang;
    xe = CW'(x) <<< 8;
    ye = CW'(y) <<< 8;
    neg_in  = x[MV_WIDTH-1];
    zero_in = (x == '0) && (y == '0);
    if (neg_in) begin
      xe = -xe;
      ye = -ye;
    end
    for (int k = 0; k < ANGLE_STAGES; k++) begin
      pxs = (k == 0) ? xe : xs_q[(k == 0) ? 0 : k - 1];
      pys = (k == 0) ? ye : ys_q[(k == 0) ? 0 : k - 1];
      pz  = (k == 0) ? '0 : z_q[(k == 0) ? 0 : k - 1];
      dx  = pys >>> k;
      dy  = pxs >>> k;
      ang = $signed({{(ZW - mvc_pkg::ANG_W){1'b0}}, mvc_pkg::atan_angle(k)});
      if (!pys[CW-1]) begin
        xs_next[k] = pxs + dx;
        ys_next[k] = pys - dy;
        z_next[k]  = pz + ang;
      end else begin
        xs_next[k] = pxs - dx;
        ys_next[k] = pys + dy;
        z_next[k]  = pz - ang;
      end
    end
    h_sum = z_q[ANGLE_STAGES-1];
    if (neg_q[ANGLE_STAGES-1]) begin
      h_sum = h_sum + ZW'(mvc_pkg::HUE_HALF);
    end
    if (h_sum < 0) begin
      h_sum = h_sum + ZW'(mvc_pkg::HUE_FULL);
    end else if (h_sum >= ZW'(mvc_pkg::HUE_FULL)) begin
      h_sum = h_sum - ZW'(mvc_pkg::HUE_FULL);
    end
    if (zero_q[ANGLE_STAGES-1]) begin
      h_sum = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ANGLE_STAGES; k++) begin
      xs_q[k] <= xs_next[k];
      ys_q[k] <= ys_next[k];
      z_q[k]  <= z_next[k];
      neg_q[k]  <= (k == 0) ? neg_in  : neg_q[(k == 0) ? 0 : k - 1];
      zero_q[k] <= (k == 0) ? zero_in : zero_q[(k == 0) ? 0 : k - 1];
    end
    hue <= h_sum[mvc_pkg::HUE_W-1:0];
  end

endmodule

// ----- hw/rtl/mvc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a sideband tag.
module mvc_div #(
  parameter int NUM_W = 58,
  parameter int DEN_W = 28,
  parameter int Q_W   = 33,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [Q_W-1:0]   quo,
  output logic [TAG_W-1:0] out_tag
);

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   low_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [TAG_W-1:0] tag_q [Q_W];
  logic             vld_q [Q_W];

  logic [DEN_W-1:0] rem_next [Q_W];
  logic [Q_W-1:0]   low_next [Q_W];
  logic [Q_W-1:0]   quo_next [Q_W];

  logic [NUM_W-1:0] num_hi;

  always_comb begin
    logic [DEN_W-1:0] prem, pden;
    logic [Q_W-1:0]   plow, pquo;
    logic [DEN_W:0]   t;
    num_hi = num >> Q_W;
    for (int k = 0; k < Q_W; k++) begin
      prem = (k == 0) ? num_hi[DEN_W-1:0] : rem_q[(k == 0) ? 0 : k - 1];
      plow = (k == 0) ? num[Q_W-1:0]      : low_q[(k == 0) ? 0 : k - 1];
      pquo = (k == 0) ? '0                : quo_q[(k == 0) ? 0 : k - 1];
      pden = (k == 0) ? den               : den_q[(k == 0) ? 0 : k - 1];
      t = {prem, plow[Q_W-1]};
      low_next[k] = plow << 1;
      if (t >= {1'b0, pden}) begin
        rem_next[k] = DEN_W'(t - {1'b0, pden});
        quo_next[k] = {pquo[Q_W-2:0], 1'b1};
      end else begin
        rem_next[k] = t[DEN_W-1:0];
        quo_next[k] = {pquo[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      rem_q[k] <= rem_next[k];
      low_q[k] <= low_next[k];
      quo_q[k] <= quo_next[k];
      den_q[k] <= (k == 0) ? den    : den_q[(k == 0) ? 0 : k - 1];
      tag_q[k] <= (k == 0) ? in_tag : tag_q[(k == 0) ? 0 : k - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Q_W; k++) vld_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < Q_W; k++) begin
        vld_q[k] <= (k == 0) ? in_vld : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_vld = vld_q[Q_W-1];
  assign quo     = quo_q[Q_W-1];
  assign out_tag = tag_q[Q_W-1];

endmodule

// ----- hw/rtl/mvc_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with a sideband tag.
module mvc_sqrt #(
  parameter int R_W   = 17,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [2*R_W-1:0]   a,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [R_W-1:0]     root,
  output logic [TAG_W-1:0]   out_tag
);

  localparam int IN_W = 2 * R_W;
  localparam int RM_W = R_W + 2;

  logic [RM_W-1:0]  rem_q  [R_W];
  logic [IN_W-1:0]  low_q  [R_W];
  logic [R_W-1:0]   root_q [R_W];
  logic [TAG_W-1:0] tag_q  [R_W];
  logic             vld_q  [R_W];

  logic [RM_W-1:0]  rem_next  [R_W];
  logic [IN_W-1:0]  low_next  [R_W];
  logic [R_W-1:0]   root_next [R_W];

  always_comb begin
    logic [RM_W-1:0] prem;
    logic [IN_W-1:0] plow;
    logic [R_W-1:0]  proot;
    logic [RM_W+1:0] t, trial;
    for (int k = 0; k < R_W; k++) begin
      prem  = (k == 0) ? '0 : rem_q[(k == 0) ? 0 : k - 1];
      plow  = (k == 0) ? a  : low_q[(k == 0) ? 0 : k - 1];
      proot = (k == 0) ? '0 : root_q[(k == 0) ? 0 : k - 1];
      t     = {prem, plow[IN_W-1:IN_W-2]};
      trial = (RM_W + 2)'({proot, 2'b01});
      low_next[k] = plow << 2;
      if (t >= trial) begin
        rem_next[k]  = RM_W'(t - trial);
        root_next[k] = {proot[R_W-2:0], 1'b1};
      end else begin
        rem_next[k]  = t[RM_W-1:0];
        root_next[k] = {proot[R_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < R_W; k++) begin
      rem_q[k]  <= rem_next[k];
      low_q[k]  <= low_next[k];
      root_q[k] <= root_next[k];
      tag_q[k]  <= (k == 0) ? in_tag : tag_q[(k == 0) ? 0 : k - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < R_W; k++) vld_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < R_W; k++) begin
        vld_q[k] <= (k == 0) ? in_vld : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_vld = vld_q[R_W-1];
  assign root    = root_q[R_W-1];
  assign out_tag = tag_q[R_W-1];

endmodule

// ----- hw/rtl/mvc_color.sv -----
// HSV to BGR conversion in three register stages.
module mvc_color (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  mvc_pkg::mvc_pix_t             pix,
  output logic                          done,
  output logic [mvc_pkg::CHAN_W-1:0]    blue,
  output logic [mvc_pkg::CHAN_W-1:0]    green,
  output logic [mvc_pkg::CHAN_W-1:0]    red,
  output logic                          over_range
);

  localparam int RW = mvc_pkg::ROOT_W;
  localparam int DW = mvc_pkg::Q_W;
  localparam int TW = 49;
  localparam logic [RW-1:0] ONE_Q16 = 17'h10000;
  localparam logic [DW-1:0] ONE_Q32 = 33'h100000000;

  function automatic logic [mvc_pkg::CHAN_W-1:0] chan(input logic [TW-1:0] t);
    logic [57:0] w;
    logic [8:0]  c;
    w = (58'(t) << 8) - 58'(t) + (58'(1) << 47);
    c = w[56:48];
    return (c > 9'd255) ? 8'd255 : c[7:0];
  endfunction

  // stage A
  logic                       a_vld, a_over;
  logic [RW-1:0]              a_v;
  logic [DW-1:0]              a_dp, a_dq, a_dt;
  logic [mvc_pkg::SEC_W-1:0]  a_sec;
  logic [RW-1:0]              s_in, v_in, nf;
  logic [DW-1:0]              p1;
  logic [DW:0]                p2;
  logic [mvc_pkg::FRAC_W-1:0] f;

  always_comb begin
    s_in = pix.over ? ONE_Q16 : pix.root;
    v_in = pix.over ? pix.root : ONE_Q16;
    f    = pix.hue[mvc_pkg::FRAC_W-1:0];
    nf   = ONE_Q16 - {1'b0, f};
    p1   = s_in * f;
    p2   = s_in * nf;
  end

  // stage B
  logic                       b_vld, b_over;
  logic [TW-1:0]              b_tv, b_tp, b_tq, b_tt;
  logic [mvc_pkg::SEC_W-1:0]  b_sec;
  logic [RW+DW-1:0]           m_p, m_q, m_t;

  always_comb begin
    m_p = a_v * a_dp;
    m_q = a_v * a_dq;
    m_t = a_v * a_dt;
  end

  // stage C
  logic [TW-1:0] r_t, g_t, b_t;

  always_comb begin
    case (b_sec)
      3'd0:    begin r_t = b_tv; g_t = b_tt; b_t = b_tp; end
      3'd1:    begin r_t = b_tq; g_t = b_tv; b_t = b_tp; end
      3'd2:    begin r_t = b_tp; g_t = b_tv; b_t = b_tt; end
      3'd3:    begin r_t = b_tp; g_t = b_tq; b_t = b_tv; end
      3'd4:    begin r_t = b_tt; g_t = b_tp; b_t = b_tv; end
      default: begin r_t = b_tv; g_t = b_tp; b_t = b_tq; end
    endcase
  end

  always_ff @(posedge clk) begin
    a_over <= pix.over;
    a_v    <= v_in;
    a_sec  <= pix.hue[mvc_pkg::HUE_W-1:mvc_pkg::FRAC_W];
    a_dp   <= ONE_Q32 - {s_in, 16'b0};
    a_dq   <= ONE_Q32 - p1;
    a_dt   <= DW'({1'b0, ONE_Q32} - p2);
    b_over <= a_over;
    b_sec  <= a_sec;
    b_tv   <= {a_v, 32'b0};
    b_tp   <= m_p[TW-1:0];
    b_tq   <= m_q[TW-1:0];
    b_tt   <= m_t[TW-1:0];
    blue       <= chan(b_t);
    green      <= chan(g_t);
    red        <= chan(r_t);
    over_range <= b_over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      a_vld <= in_vld;
      b_vld <= a_vld;
      done  <= b_vld;
    end
  end

endmodule

// ----- hw/rtl/motion_vector_to_color.sv -----
// Top level of the motion vector to color block.
// Use: drive mv_x and mv_y and raise start; a transfer takes place at every edge
// with start high and busy low. busy is high only during reset, so one vector may enter
// every cycle.
// Each result (blue, green, red, over_range) is on the outputs for one cycle with done
// high, in input order. Its path runs through the input, square and limit stages, the
// 33-stage divider, the 17-stage square root and three color stages; the hue CORDIC runs
// alongside. Throughput is one vector per clock. The receiver cannot stall, so results
// leave on schedule. max_magnitude sits at byte address 0 of the APB port (pready always
// high). The user must write it only while no vector is in flight; the block does not
// enforce this. Zero is treated as one. A synchronous reset drops any vectors in flight
// and sets max_magnitude to 40.
module motion_vector_to_color #(
  parameter int MV_WIDTH     = mvc_pkg::MV_WIDTH_DEF,
  parameter int ANGLE_STAGES = mvc_pkg::ANGLE_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [MV_WIDTH-1:0]      mv_x,
  input  logic signed [MV_WIDTH-1:0]      mv_y,
  output logic                            done,
  output logic [mvc_pkg::CHAN_W-1:0]      blue,
  output logic [mvc_pkg::CHAN_W-1:0]      green,
  output logic [mvc_pkg::CHAN_W-1:0]      red,
  output logic                            over_range,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mvc_pkg::PADDR_W-1:0]     paddr,
  input  logic [mvc_pkg::PDATA_W-1:0]     pwdata,
  output logic [mvc_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  localparam int LW    = 2 * MV_WIDTH;
  localparam int VNUM_W = mvc_pkg::LIM_W + mvc_pkg::V_SHIFT;
  localparam int NUM_W = (LW + mvc_pkg::S_SHIFT > VNUM_W) ? LW + mvc_pkg::S_SHIFT : VNUM_W;
  localparam int DEN_W = (LW > mvc_pkg::SQ_W) ? LW : mvc_pkg::SQ_W;
  localparam int CMP_W = (LW > mvc_pkg::LIM_W) ? LW : mvc_pkg::LIM_W;
  localparam int HUE_DLY = 1 + mvc_pkg::Q_W + mvc_pkg::ROOT_W - ANGLE_STAGES;
  localparam int LAT   = 6 + mvc_pkg::Q_W + mvc_pkg::ROOT_W;

  logic                     in_xfer;
  logic [mvc_pkg::MAG_W-1:0] max_magnitude;

  assign busy    = rst;
  assign pready  = 1'b1;
  assign in_xfer = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_magnitude <= mvc_pkg::MAX_MAG_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[mvc_pkg::PADDR_W-1] == mvc_pkg::REG_MAX_MAG) begin
      max_magnitude <= pwdata[mvc_pkg::MAG_W-1:0];
    end
  end

  assign prdata = (paddr[mvc_pkg::PADDR_W-1] == mvc_pkg::REG_MAX_MAG) ?
                  mvc_pkg::PDATA_W'(max_magnitude) : '0;

  // s0: input
  logic                        v0;
  logic signed [MV_WIDTH-1:0]  x0, y0;
  logic [mvc_pkg::MAG_W-1:0]   m0;
  // s1: squares
  logic                        v1;
  logic [LW-1:0]               xx, yy;
  logic [mvc_pkg::SQ_W-1:0]    mm2;
  logic signed [LW-1:0]        x_sq, y_sq;
  // s2: divider operands
  logic                        v2, over2;
  logic [NUM_W-1:0]            num2;
  logic [DEN_W-1:0]            den2;
  logic [LW-1:0]               l2;
  logic [mvc_pkg::LIM_W-1:0]   lim;
  logic                        over_c;

  always_comb begin
    x_sq   = x0 * x0;
    y_sq   = y0 * y0;
    l2     = xx + yy;
    lim    = {mm2, 4'b0};
    over_c = CMP_W'(l2) > CMP_W'(lim);
  end

  always_ff @(posedge clk) begin
    x0   <= mv_x;
    y0   <= mv_y;
    m0   <= (max_magnitude == '0) ? mvc_pkg::MAG_W'(1) : max_magnitude;
    xx   <= x_sq;
    yy   <= y_sq;
    mm2  <= m0 * m0;
    over2 <= over_c;
    num2 <= over_c ? (NUM_W'(lim) << mvc_pkg::V_SHIFT) : (NUM_W'(l2) << mvc_pkg::S_SHIFT);
    den2 <= over_c ? DEN_W'(l2) : DEN_W'(mm2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= in_xfer;
      v1 <= v0;
      v2 <= v1;
    end
  end

  logic                      dv_vld, dv_over, sq_vld, sq_over;
  logic [mvc_pkg::Q_W-1:0]   quo;
  logic [mvc_pkg::ROOT_W-1:0] root;
  logic [mvc_pkg::HUE_W-1:0] hue_c;
  logic [mvc_pkg::HUE_W-1:0] hue_dly [HUE_DLY];
  mvc_pkg::mvc_pix_t         pix;

  mvc_cordic #(
    .MV_WIDTH     (MV_WIDTH),
    .ANGLE_STAGES (ANGLE_STAGES)
  ) u_cordic (
    .clk (clk),
    .x   (x0),
    .y   (y0),
    .hue (hue_c)
  );

  always_ff @(posedge clk) begin
    for (int k = 0; k < HUE_DLY; k++) begin
      hue_dly[k] <= (k == 0) ? hue_c : hue_dly[(k == 0) ? 0 : k - 1];
    end
  end

  mvc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (mvc_pkg::Q_W),
    .TAG_W (1)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v2),
    .num     (num2),
    .den     (den2),
    .in_tag  (over2),
    .out_vld (dv_vld),
    .quo     (quo),
    .out_tag (dv_over)
  );

  mvc_sqrt #(
    .R_W   (mvc_pkg::ROOT_W),
    .TAG_W (1)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (dv_vld),
    .a       ({1'b0, quo}),
    .in_tag  (dv_over),
    .out_vld (sq_vld),
    .root    (root),
    .out_tag (sq_over)
  );

  assign pix.over = sq_over;
  assign pix.root = root;
  assign pix.hue  = hue_dly[HUE_DLY-1];

  mvc_color u_color (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (sq_vld),
    .pix        (pix),
    .done       (done),
    .blue       (blue),
    .green      (green),
    .red        (red),
    .over_range (over_range)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> ##LAT done)
    else $error("result missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_xfer, LAT))
    else $error("result without matching input transfer");

  a_over_dark: assert property (@(posedge clk) disable iff (rst)
    done && over_range |-> (blue == '0 || green == '0 || red == '0))
    else $error("over-range color has no zero channel");

  a_full_value: assert property (@(posedge clk) disable iff (rst)
    done && !over_range |-> (blue == 8'd255 || green == 8'd255 || red == 8'd255))
    else $error("in-range color has no full channel");

endmodule
